/* hdl/iirdf1_pkg.sv */
// shared types, constants and reset values for the direct form one iir filter
// no dependencies; used by the interfaces, the tap cell, the top level and the checker
package iirdf1_pkg;

  // fixed widths and register map
  localparam int COEF_BITS     = 16;
  localparam int MAX_TAPS      = 4;
  localparam int TAP_IDX_BITS  = $clog2(MAX_TAPS);
  localparam int NUM_REGS      = 2 * MAX_TAPS;
  localparam int CFG_IDX_BITS  = 4;

  // defaults handed to the top level parameters
  localparam int DEF_FF_TAPS        = 2;
  localparam int DEF_FB_TAPS        = 2;
  localparam int DEF_SAMPLE_BITS    = 16;
  localparam int DEF_COEF_FRAC_BITS = 13;

  typedef logic [CFG_IDX_BITS-1:0]     reg_idx_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  // register indexes
  localparam reg_idx_t REG_FF_COEF_0 = reg_idx_t'(0);
  localparam reg_idx_t REG_FF_COEF_1 = reg_idx_t'(1);
  localparam reg_idx_t REG_FF_COEF_2 = reg_idx_t'(2);
  localparam reg_idx_t REG_FF_COEF_3 = reg_idx_t'(3);
  localparam reg_idx_t REG_FB_COEF_1 = reg_idx_t'(4);
  localparam reg_idx_t REG_FB_COEF_2 = reg_idx_t'(5);
  localparam reg_idx_t REG_FB_COEF_3 = reg_idx_t'(6);
  localparam reg_idx_t REG_FB_COEF_4 = reg_idx_t'(7);
  localparam reg_idx_t REG_LIMIT     = reg_idx_t'(NUM_REGS);

  // coefficient reset values, Q3.13
  localparam coef_t RST_FF_COEF [MAX_TAPS] = '{16'sd8192, 16'sd16384, 16'sd0, 16'sd0};
  localparam coef_t RST_FB_COEF [MAX_TAPS] = '{-16'sd8192, 16'sd8192, 16'sd0, 16'sd0};

  // control handed along the row of tap cells
  typedef struct packed {
    logic shift;
    logic clear;
  } tap_ctrl_t;

endpackage

/* hdl/iirdf1_if.sv */
// channel interfaces of the direct form one iir filter: input samples, results, register writes
// depends on iirdf1_pkg for default widths
interface iirdf1_smp_in_if #(
  parameter int SAMPLE_BITS = iirdf1_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          end_of_block;

  modport source (output valid, sample_in, end_of_block, input ready);
  modport sink   (input valid, sample_in, end_of_block, output ready);
endinterface

interface iirdf1_smp_out_if #(
  parameter int SAMPLE_BITS = iirdf1_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

interface iirdf1_cfg_if;
  logic                     valid;
  logic                     ready;
  iirdf1_pkg::reg_idx_t     index;
  iirdf1_pkg::coef_t        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/iir_direct_form_one_filter.sv */
// direct form one iir filter top level: coefficient registers, tap cell rows, sum, round, saturate
// depends on iirdf1_pkg, iirdf1_if and iirdf1_tap_cell
//
//  channel  | role   | payload                     | transfer when
//  ---------+--------+-----------------------------+------------------------
//  in_ch    | sink   | sample_in, end_of_block     | valid & ready
//  out_ch   | source | sample_out, saturated       | valid & ready
//  cfg_ch   | sink   | index, data                 | valid & ready (ready = 1)
//
// one sample per clock while out_ch takes the results: the result of a sample accepted
// at one edge shows on out_ch from the next cycle; the loop through the feedback products,
// the sum and the saturation is combinational up to the feedback delay registers. in_ch.ready
// is high while the output register is empty or being emptied, so a held result stalls input
// only until it is taken. reset (synchronous, rst_n low) clears both delay rows and the output
// valid flag and loads the coefficient reset values.
module iir_direct_form_one_filter #(
  parameter int FF_TAPS        = iirdf1_pkg::DEF_FF_TAPS,
  parameter int FB_TAPS        = iirdf1_pkg::DEF_FB_TAPS,
  parameter int SAMPLE_BITS    = iirdf1_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = iirdf1_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  iirdf1_smp_in_if.sink     in_ch,
  iirdf1_smp_out_if.source  out_ch,
  iirdf1_cfg_if.sink        cfg_ch
);

  localparam int PROD_W = SAMPLE_BITS + iirdf1_pkg::COEF_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

  iirdf1_pkg::coef_t ff_coef_r [iirdf1_pkg::MAX_TAPS];
  iirdf1_pkg::coef_t fb_coef_r [iirdf1_pkg::MAX_TAPS];

  logic                          in_xfer;
  iirdf1_pkg::tap_ctrl_t         ctrl;
  logic signed [SAMPLE_BITS-1:0] ff_smp  [FF_TAPS];
  logic signed [PROD_W-1:0]      ff_prod [FF_TAPS];
  logic signed [SAMPLE_BITS-1:0] fb_smp  [FB_TAPS+1];
  logic signed [PROD_W-1:0]      fb_prod [FB_TAPS];
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       quo;
  logic                          sat_hi;
  logic                          sat_lo;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_out_r;
  logic                          saturated_r;

  // coefficient registers; writes beyond the map are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_coef_r <= iirdf1_pkg::RST_FF_COEF;
      fb_coef_r <= iirdf1_pkg::RST_FB_COEF;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index < iirdf1_pkg::REG_FB_COEF_1) begin
        ff_coef_r[cfg_ch.index[iirdf1_pkg::TAP_IDX_BITS-1:0]] <= cfg_ch.data;
      end else if (cfg_ch.index < iirdf1_pkg::REG_LIMIT) begin
        fb_coef_r[cfg_ch.index[iirdf1_pkg::TAP_IDX_BITS-1:0]] <= cfg_ch.data;
      end
    end
  end

  // input handshake and tap control
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign ctrl.shift  = in_xfer;
  assign ctrl.clear  = in_xfer && in_ch.end_of_block;

  // current sample tap
  assign ff_smp[0]  = in_ch.sample_in;
  assign ff_prod[0] = ff_coef_r[0] * ff_smp[0];

  // feedforward delay row
  for (genvar k = 1; k < FF_TAPS; k++) begin : g_ff
    iirdf1_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .smp_in  (ff_smp[k-1]),
      .coef    (ff_coef_r[k]),
      .smp_out (ff_smp[k]),
      .prod    (ff_prod[k])
    );
  end

  // feedback delay row, fed by the saturated output
  assign fb_smp[0] = y_sat;

  for (genvar j = 1; j <= FB_TAPS; j++) begin : g_fb
    iirdf1_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .smp_in  (fb_smp[j-1]),
      .coef    (fb_coef_r[j-1]),
      .smp_out (fb_smp[j]),
      .prod    (fb_prod[j-1])
    );
  end

  // full precision sum with rounding offset
  always_comb begin
    acc = RND;
    for (int k = 0; k < FF_TAPS; k++) begin
      acc = acc + ACC_W'(ff_prod[k]);
    end
    for (int j = 0; j < FB_TAPS; j++) begin
      acc = acc - ACC_W'(fb_prod[j]);
    end
  end

  // floor shift and saturation
  assign quo    = acc >>> COEF_FRAC_BITS;
  assign sat_hi = quo > SMAX;
  assign sat_lo = quo < SMIN;

  always_comb begin
    if (sat_hi) begin
      y_sat = SMAX[SAMPLE_BITS-1:0];
    end else if (sat_lo) begin
      y_sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = quo[SAMPLE_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_out_r <= y_sat;
      saturated_r  <= sat_hi || sat_lo;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = sample_out_r;
  assign out_ch.saturated  = saturated_r;

endmodule

/* hdl/iirdf1_tap_cell.sv */
// one delay tap: holds a past sample, passes it to the next cell and weights it by its coefficient
// depends on iirdf1_pkg for the coefficient type and the control struct
module iirdf1_tap_cell #(
  parameter int SAMPLE_BITS = iirdf1_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  iirdf1_pkg::tap_ctrl_t                             ctrl,
  input  logic signed [SAMPLE_BITS-1:0]                     smp_in,
  input  iirdf1_pkg::coef_t                                 coef,
  output logic signed [SAMPLE_BITS-1:0]                     smp_out,
  output logic signed [SAMPLE_BITS+iirdf1_pkg::COEF_BITS-1:0] prod
);

  logic signed [SAMPLE_BITS-1:0] smp_r;

  // delay register; clear wins over shift, so at end of block the register is cleared, not loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
    end else if (ctrl.clear) begin
      smp_r <= '0;
    end else if (ctrl.shift) begin
      smp_r <= smp_in;
    end
  end

  assign smp_out = smp_r;

  // tap product, full precision
  assign prod = coef * smp_r;

endmodule

/* hdl/iirdf1_checker.sv */
// port level checks of the direct form one iir filter, attached to the top level by bind
// depends on iirdf1_pkg for the default sample width
module iirdf1_port_props #(
  parameter int SAMPLE_BITS = iirdf1_pkg::DEF_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic                          saturated
);

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // every input transfer gives a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer without result");

  // no result invented once the last one is taken
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
    else $error("result repeated or invented");

  // a clipped result sits at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> sample_out == SMAX || sample_out == SMIN)
    else $error("saturation flag without clipped value");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(saturated))
    else $error("stalled result changed");

endmodule

bind iir_direct_form_one_filter iirdf1_port_props #(.SAMPLE_BITS(SAMPLE_BITS)) u_iirdf1_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sample_out (out_ch.sample_out),
  .saturated  (out_ch.saturated)
);
